/* src/lfpd_pkg.sv */
// Shared types, register codes, pattern table and divide helper for the line follower drive.
package lfpd_pkg;

  localparam int unsigned LFPD_QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam logic [2:0] CFG_GAIN_P     = 3'd0;
  localparam logic [2:0] CFG_GAIN_I     = 3'd1;
  localparam logic [2:0] CFG_GAIN_D     = 3'd2;
  localparam logic [2:0] CFG_BASE_SPEED = 3'd3;
  localparam logic [2:0] CFG_PWM_TOP    = 3'd4;

  localparam logic [7:0]  RST_GAIN_P     = 8'd40;
  localparam logic [7:0]  RST_GAIN_I     = 8'd0;
  localparam logic [7:0]  RST_GAIN_D     = 8'd15;
  localparam logic [7:0]  RST_BASE_SPEED = 8'd110;
  localparam logic [15:0] RST_PWM_TOP    = 16'd20000;

  localparam logic [7:0] DUTY_FULL = 8'd255;

  // steer directions
  localparam logic [1:0] DIR_FWD       = 2'd0;
  localparam logic [1:0] DIR_RIGHT_OFF = 2'd1;
  localparam logic [1:0] DIR_LEFT_OFF  = 2'd2;
  localparam logic [1:0] DIR_KEEP      = 2'd3;

  // pattern status
  localparam logic [2:0] PST_TRACK     = 3'd0;
  localparam logic [2:0] PST_SHARP_L   = 3'd1;
  localparam logic [2:0] PST_SHARP_R   = 3'd2;
  localparam logic [2:0] PST_ALL_OFF   = 3'd3;
  localparam logic [2:0] PST_ALL_ON    = 3'd4;
  localparam logic [2:0] PST_UNMATCHED = 3'd5;

  typedef struct packed {
    logic [7:0]  gain_p;
    logic [7:0]  gain_i;
    logic [7:0]  gain_d;
    logic [7:0]  base_speed;
    logic [15:0] pwm_top;
  } lfpd_cfg_t;

  typedef struct packed {
    logic signed [4:0] err;
    logic [1:0]        dir;
    logic [2:0]        status;
  } lfpd_class_t;

  // one classified item handed from front to back
  typedef struct packed {
    logic signed [4:0]  err;
    logic signed [5:0]  diff;
    logic signed [15:0] sum;
    logic [1:0]         dir;
    logic [2:0]         status;
  } lfpd_job_t;

  function automatic lfpd_class_t lfpd_classify(input logic [4:0] s,
                                                 input logic signed [4:0] held);
    lfpd_class_t c;
    c.dir    = DIR_KEEP;
    c.status = PST_TRACK;
    c.err    = held;
    case (s)
      5'd27: begin c.err = 5'sd0;  c.dir = DIR_FWD;       end
      5'd25: begin c.err = -5'sd1; c.dir = DIR_RIGHT_OFF; end
      5'd19: begin c.err = 5'sd1;  c.dir = DIR_LEFT_OFF;  end
      5'd29: begin c.err = -5'sd2; c.dir = DIR_RIGHT_OFF; end
      5'd23: begin c.err = 5'sd2;  c.dir = DIR_LEFT_OFF;  end
      5'd28: begin c.err = -5'sd3; c.dir = DIR_RIGHT_OFF; end
      5'd7:  begin c.err = 5'sd3;  c.dir = DIR_LEFT_OFF;  end
      5'd30: begin c.err = -5'sd4; c.dir = DIR_RIGHT_OFF; end
      5'd15: begin c.err = 5'sd4;  c.dir = DIR_LEFT_OFF;  end
      5'd24: begin c.err = 5'sd10; c.status = PST_SHARP_L; end
      5'd3:  begin c.err = 5'sd11; c.status = PST_SHARP_R; end
      5'd31: begin c.err = 5'sd12; c.status = PST_ALL_OFF; end
      5'd0:  begin c.err = 5'sd13; c.status = PST_ALL_ON;  end
      default: begin c.status = PST_UNMATCHED; end
    endcase
    return c;
  endfunction

  // floor(x / 255) for x < 255*65537: estimate x*257/2^16 is q or q-1, one correction
  function automatic logic [15:0] lfpd_div255(input logic [23:0] x);
    logic [31:0] t;
    logic [15:0] est;
    logic [24:0] r;
    t   = {x, 8'b0} + {8'b0, x};
    est = t[31:16];
    r   = {1'b0, x} + {9'b0, est} - {1'b0, est, 8'b0};
    return (r >= 25'(DUTY_FULL)) ? est + 16'd1 : est;
  endfunction

endpackage

/* src/lfpd_front.sv */
// Front end: classifies sensor items, tracks error and integral, pushes jobs.
module lfpd_front import lfpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [4:0] sensor_bits_i,
  input  logic       full_i,
  output logic       push_o,
  output lfpd_job_t  job_o
);

  logic signed [4:0]  err_q, err_d;
  logic signed [15:0] sum_q, sum_d;
  logic signed [16:0] sum_wide;
  lfpd_class_t        cls;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    cls      = lfpd_classify(sensor_bits_i, err_q);
    err_d    = cls.err;
    sum_wide = {sum_q[15], sum_q} + {{12{cls.err[4]}}, cls.err};
    if (sum_wide[16] != sum_wide[15]) begin
      sum_d = sum_wide[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      sum_d = sum_wide[15:0];
    end
    job_o.err    = cls.err;
    job_o.diff   = {cls.err[4], cls.err} - {err_q[4], err_q};
    job_o.sum    = sum_d;
    job_o.dir    = cls.dir;
    job_o.status = cls.status;
  end

  // held error doubles as the previous error: both equal the last item's error
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= '0;
      sum_q <= '0;
    end else if (push_o) begin
      err_q <= err_d;
      sum_q <= sum_d;
    end
  end

endmodule

/* src/lfpd_queue.sv */
// Small FIFO of classified jobs between front and back.
module lfpd_queue #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* src/lfpd_back.sv */
// Back end: PID sum on a shared multiplier, clamp, PWM scaling, output register.
module lfpd_back import lfpd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lfpd_cfg_t         cfg_i,
  input  logic              empty_i,
  input  lfpd_job_t         job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       left_compare_o,
  output logic [15:0]       right_compare_o,
  output logic [1:0]        steer_dir_o,
  output logic [2:0]        pattern_status_o,
  output logic signed [4:0] line_error_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MP   = 4'd1;
  localparam logic [3:0] S_MI   = 4'd2;
  localparam logic [3:0] S_MD   = 4'd3;
  localparam logic [3:0] S_DUTY = 4'd4;
  localparam logic [3:0] S_SL   = 4'd5;
  localparam logic [3:0] S_QL   = 4'd6;
  localparam logic [3:0] S_QR   = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]         state_q, state_d;
  logic               out_valid_q, out_valid_d;
  lfpd_job_t          job_q, job_d;
  logic signed [26:0] acc_q, acc_d;
  logic [7:0]         duty_l_q, duty_l_d, duty_r_q, duty_r_d;
  logic [23:0]        scale_q, scale_d;
  logic [15:0]        left_q, left_d, right_q, right_d;
  logic               load;

  logic [7:0]         mul_a;
  logic signed [16:0] mul_b;
  logic signed [25:0] prod;
  logic signed [27:0] sum_l, sum_r;
  logic [7:0]         scale_duty;

  logic [15:0]        o_left_q, o_right_q;
  logic [1:0]         o_dir_q;
  logic [2:0]         o_status_q;
  logic signed [4:0]  o_err_q;

  function automatic logic [7:0] clamp_duty(input logic signed [27:0] v);
    if (v[27]) begin
      return 8'd0;
    end else if (v > 28'sd255) begin
      return DUTY_FULL;
    end
    return v[7:0];
  endfunction

  assign prod = $signed({1'b0, mul_a}) * mul_b;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    job_d       = job_q;
    acc_d       = acc_q;
    duty_l_d    = duty_l_q;
    duty_r_d    = duty_r_q;
    scale_d     = scale_q;
    left_d      = left_q;
    right_d     = right_q;
    pop_o       = 1'b0;
    load        = 1'b0;
    mul_a       = cfg_i.gain_p;
    mul_b       = {{12{job_q.err[4]}}, job_q.err};
    scale_duty  = duty_l_q;
    sum_l       = {20'b0, cfg_i.base_speed} + {acc_q[26], acc_q};
    sum_r       = {20'b0, cfg_i.base_speed} - {acc_q[26], acc_q};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          state_d = S_MP;
        end
      end
      S_MP: begin
        acc_d   = {prod[25], prod};
        state_d = S_MI;
      end
      S_MI: begin
        mul_a   = cfg_i.gain_i;
        mul_b   = {job_q.sum[15], job_q.sum};
        acc_d   = acc_q + {prod[25], prod};
        state_d = S_MD;
      end
      S_MD: begin
        mul_a   = cfg_i.gain_d;
        mul_b   = {{11{job_q.diff[5]}}, job_q.diff};
        acc_d   = acc_q + {prod[25], prod};
        state_d = S_DUTY;
      end
      S_DUTY: begin
        duty_l_d = clamp_duty(sum_l);
        duty_r_d = clamp_duty(sum_r);
        state_d  = S_SL;
      end
      S_SL: begin
        scale_d = scale_duty * cfg_i.pwm_top;
        state_d = S_QL;
      end
      S_QL: begin
        left_d     = lfpd_div255(scale_q);
        scale_duty = duty_r_q;
        scale_d    = scale_duty * cfg_i.pwm_top;
        state_d    = S_QR;
      end
      S_QR: begin
        right_d = lfpd_div255(scale_q);
        state_d = S_OUT;
      end
      S_OUT: begin
        // wait here while the previous item still sits unaccepted
        if (!out_valid_q || out_ready_i) begin
          load        = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    acc_q    <= acc_d;
    duty_l_q <= duty_l_d;
    duty_r_q <= duty_r_d;
    scale_q  <= scale_d;
    left_q   <= left_d;
    right_q  <= right_d;
    if (load) begin
      o_left_q   <= left_q;
      o_right_q  <= right_q;
      o_dir_q    <= job_q.dir;
      o_status_q <= job_q.status;
      o_err_q    <= job_q.err;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign left_compare_o   = o_left_q;
  assign right_compare_o  = o_right_q;
  assign steer_dir_o      = o_dir_q;
  assign pattern_status_o = o_status_q;
  assign line_error_o     = o_err_q;

endmodule

/* src/line_follow_pid_drive_top.sv */
// Top level of the line follower PID drive: config registers, front, queue, back.
//
// Input channel: in_valid_i/in_ready_o carry one 5-bit sensor_bits_i item.
// Output channel: out_valid_o/out_ready_i carry both PWM compares, the steer
// direction, the pattern status and the error in use after the item.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (gain_p, gain_i, gain_d, base_speed, pwm_top); other indexes are ignored.
// The front classifies an item in the cycle it is accepted and pushes it into
// a QUEUE_DEPTH-entry queue; in_ready_o drops only while that queue is full.
// The back sequencer works on one item at a time and pops the next only after
// it has loaded the last one: one pop, three multiply-add steps on a shared
// 8x17 multiplier, clamp, two 8x16 scale multiplies with their divide-by-255
// steps, and the output load.
// A stalled receiver holds the output register; the back then waits with its
// next result while the front keeps accepting until the queue fills.
// Reset restores the register defaults and clears error, integral and queue.
module line_follow_pid_drive_top import lfpd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = LFPD_QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [4:0]        sensor_bits_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       left_compare_o,
  output logic [15:0]       right_compare_o,
  output logic [1:0]        steer_dir_o,
  output logic [2:0]        pattern_status_o,
  output logic signed [4:0] line_error_o
);

  lfpd_cfg_t cfg_q;
  lfpd_job_t push_job, pop_job;
  logic      push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p     <= RST_GAIN_P;
      cfg_q.gain_i     <= RST_GAIN_I;
      cfg_q.gain_d     <= RST_GAIN_D;
      cfg_q.base_speed <= RST_BASE_SPEED;
      cfg_q.pwm_top    <= RST_PWM_TOP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAIN_P:     cfg_q.gain_p     <= cfg_data_i[7:0];
        CFG_GAIN_I:     cfg_q.gain_i     <= cfg_data_i[7:0];
        CFG_GAIN_D:     cfg_q.gain_d     <= cfg_data_i[7:0];
        CFG_BASE_SPEED: cfg_q.base_speed <= cfg_data_i[7:0];
        CFG_PWM_TOP:    cfg_q.pwm_top    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lfpd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sensor_bits_i (sensor_bits_i),
    .full_i        (full),
    .push_o        (push),
    .job_o         (push_job)
  );

  lfpd_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(lfpd_job_t))
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (pop_job)
  );

  lfpd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .empty_i          (empty),
    .job_i            (pop_job),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .left_compare_o   (left_compare_o),
    .right_compare_o  (right_compare_o),
    .steer_dir_o      (steer_dir_o),
    .pattern_status_o (pattern_status_o),
    .line_error_o     (line_error_o)
  );

endmodule

/* src/lfpd_checker.sv */
// Port-level checks for the line follower PID drive, bound to the top level.
module lfpd_checker import lfpd_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [4:0]        sensor_bits_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [15:0]       left_compare_o,
  input logic [15:0]       right_compare_o,
  input logic [1:0]        steer_dir_o,
  input logic [2:0]        pattern_status_o,
  input logic signed [4:0] line_error_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(sensor_bits_i))
    else $error("input item changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable(left_compare_o) && $stable(right_compare_o))
    else $error("output item changed while stalled");

  a_dir_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((steer_dir_o != DIR_KEEP) == (pattern_status_o == PST_TRACK)))
    else $error("steer direction disagrees with pattern status");

  a_all_on_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pattern_status_o == PST_ALL_ON |-> line_error_o == 5'sd13)
    else $error("all-on pattern without its error value");

  a_track_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pattern_status_o == PST_TRACK |->
      line_error_o >= -5'sd4 && line_error_o <= 5'sd4)
    else $error("tracking item with out-of-range error");

endmodule

bind line_follow_pid_drive_top lfpd_checker u_lfpd_checker (.*);
